// ===== rtl/bchd_pkg.sv =====
// shared constants, codes and types of the button click and hold detector
package bchd_pkg;

  // width of the tick counter, which moves once per processed tick, and the time stamps
  localparam int STAMP_BITS = 32;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int LINE_W    = 16;
  localparam int EV_W      = 2;
  localparam int STATE_W   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_CODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 3'd5;

  // configuration reset values
  localparam logic              RST_ACTIVE_LEVEL   = 1'b0;
  localparam logic [LINE_W-1:0] RST_LINE_CODE      = 16'd1;
  localparam logic [CFG_W-1:0]  RST_DEBOUNCE_TICKS = 16'd20;
  localparam logic [CFG_W-1:0]  RST_CLICK_TICKS    = 16'd300;
  localparam logic [CFG_W-1:0]  RST_RELEASE_TICKS  = 16'd200;
  localparam logic [CFG_W-1:0]  RST_HOLD_TICKS     = 16'd1000;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EV_W-1:0] EV_HOLD   = 2'd3;

  // externally visible state numbers used by the checks in the top level
  localparam logic [STATE_W-1:0] STATE_IDLE         = 4'd0;
  localparam logic [STATE_W-1:0] STATE_WAIT_RELEASE = 4'd5;

  // press and release timing windows
  typedef struct packed {
    logic [CFG_W-1:0] click_ticks;
    logic [CFG_W-1:0] release_ticks;
    logic [CFG_W-1:0] hold_ticks;
  } timing_cfg_t;

  // result of one machine step
  typedef struct packed {
    logic [EV_W-1:0]    ev_code;
    logic [STATE_W-1:0] state_code;
  } fsm_status_t;

endpackage

// ===== rtl/bchd_fsm.sv =====
// click, double-click and hold state machine with its change stamp
module bchd_fsm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic                            pressed,
  input  logic [bchd_pkg::STAMP_BITS-1:0] tick_now,
  input  bchd_pkg::timing_cfg_t           timing,
  output bchd_pkg::fsm_status_t           status
);
  import bchd_pkg::*;

  typedef enum logic [STATE_W-1:0] {
    S_IDLE         = 4'd0,
    S_PRESS        = 4'd1,
    S_WAIT_SINGLE  = 4'd2,
    S_WAIT_DOUBLE  = 4'd3,
    S_WAIT_HOLD    = 4'd4,
    S_WAIT_RELEASE = 4'd5,
    S_SINGLE       = 4'd6,
    S_DOUBLE       = 4'd7,
    S_HOLD         = 4'd8,
    S_RELEASE      = 4'd9
  } state_t;

  state_t                state_r, state_nxt;
  logic [STAMP_BITS-1:0] change_stamp_r, change_stamp_nxt;
  logic [STAMP_BITS-1:0] elapsed;
  logic                  below_click, reach_release, reach_hold;
  logic [EV_W-1:0]       ev_nxt;

  // wrapping time since the change stamp was last set (on a press, a release or a hold report)
  assign elapsed       = tick_now - change_stamp_r;
  assign below_click   = elapsed < STAMP_BITS'(timing.click_ticks);
  assign reach_release = elapsed >= STAMP_BITS'(timing.release_ticks);
  assign reach_hold    = elapsed >= STAMP_BITS'(timing.hold_ticks);

  always_comb begin
    state_nxt        = state_r;
    change_stamp_nxt = change_stamp_r;
    ev_nxt           = EV_NONE;
    case (state_r)
      S_IDLE: begin
        if (pressed) begin
          state_nxt        = S_PRESS;
          change_stamp_nxt = tick_now;
        end
      end
      S_PRESS: begin
        if (!pressed) begin
          if (below_click) begin
            state_nxt        = S_WAIT_SINGLE;
            change_stamp_nxt = tick_now;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (!below_click) begin
          state_nxt = S_WAIT_HOLD;
        end
      end
      S_WAIT_SINGLE: begin
        if (reach_release) begin
          // still pressed past the gap: stay until release
          if (!pressed) state_nxt = S_SINGLE;
        end else if (pressed) begin
          state_nxt        = S_WAIT_DOUBLE;
          change_stamp_nxt = tick_now;
        end
      end
      S_WAIT_DOUBLE: begin
        if (!pressed) begin
          state_nxt = below_click ? S_DOUBLE : S_IDLE;
        end else if (!below_click) begin
          state_nxt = S_IDLE;
        end
      end
      S_WAIT_HOLD: begin
        if (reach_hold) state_nxt = pressed ? S_HOLD : S_IDLE;
      end
      S_WAIT_RELEASE: begin
        if (!pressed && reach_release) state_nxt = S_RELEASE;
      end
      S_SINGLE: begin
        ev_nxt    = EV_SINGLE;
        state_nxt = S_IDLE;
      end
      S_DOUBLE: begin
        ev_nxt    = EV_DOUBLE;
        state_nxt = S_IDLE;
      end
      S_HOLD: begin
        ev_nxt           = EV_HOLD;
        state_nxt        = S_WAIT_RELEASE;
        change_stamp_nxt = tick_now;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      change_stamp_r <= '0;
    end else if (step) begin
      state_r        <= state_nxt;
      change_stamp_r <= change_stamp_nxt;
    end
  end

  assign status.ev_code    = ev_nxt;
  assign status.state_code = STATE_W'(state_nxt);

`ifndef SYNTHESIS
  // a report state never lasts more than one step
  a_report_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    step && (state_r == S_SINGLE || state_r == S_DOUBLE) |=> state_r == S_IDLE)
    else $error("report state did not return to idle");

  // a hold report always restarts the release timer
  a_hold_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    step && state_r == S_HOLD |=> change_stamp_r == $past(tick_now))
    else $error("hold report did not restamp");

  // the machine only moves on a step
  a_hold_still: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(step) |-> $stable(state_r) && $stable(change_stamp_r))
    else $error("machine moved without a step");
`endif

endmodule

// ===== rtl/button_click_hold_detector_core.sv =====
// top level of the button debounce and click / double-click / hold detector
//
// Each request on the input stream is one millisecond tick carrying the raw pin
// level and an optional edge notice with its line code. An edge on the
// configured line while the input is stable opens a debounce window; when the
// window runs out the pin is resampled into the clean level. A ten-state
// machine times presses and releases against the configured windows, with all
// elapsed times taken modulo 2^STAMP_BITS, and reports single click, double
// click or hold one tick after the deciding state is reached. Every tick gives
// exactly one result. The block takes one tick per clock cycle: a request
// lands in the input register, the whole tick step (counter, debounce, machine)
// is one combinational pass from there into the result register, and
// throughput is one request per cycle as long as the result side keeps
// taking. The clean level starts inactive (high) after reset. Configuration
// writes are taken at any edge with cfg_we high and are meant to happen only
// while no tick is in flight; indexes above five are ignored.
module button_click_hold_detector_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input tick stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,  // [0] pin_level, [16:1] edge_line
  input  logic                           in_tuser,  // [0] edge_seen
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata, // [1:0] event_code, [2] clean_level,
                                                    // [6:3] machine_state
  // configuration
  input  logic                           cfg_we,
  input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bchd_pkg::CFG_W-1:0]     cfg_wdata
);
  import bchd_pkg::*;

  // configuration registers
  logic              active_level_r;
  logic [LINE_W-1:0] line_code_r;
  logic [CFG_W-1:0]  debounce_ticks_r;
  logic [CFG_W-1:0]  click_ticks_r;
  logic [CFG_W-1:0]  release_ticks_r;
  logic [CFG_W-1:0]  hold_ticks_r;

  // input register
  logic              in_vld_r;
  logic              pin_r;
  logic              edge_seen_r;
  logic [LINE_W-1:0] edge_line_r;

  // debounce state
  logic [STAMP_BITS-1:0] tick_r, tick_nxt;
  logic [STAMP_BITS-1:0] deb_stamp_r, deb_stamp_nxt;
  logic [STAMP_BITS-1:0] deb_elapsed;
  logic                  settling_r, settling_nxt;
  logic                  level_r, level_nxt;
  logic                  edge_hit, settle_open, expire, pressed;

  // result register
  logic               out_vld_r;
  logic [EV_W-1:0]    out_ev_r;
  logic               out_lvl_r;
  logic [STATE_W-1:0] out_state_r;

  logic        advance;
  timing_cfg_t timing;
  fsm_status_t fsm_status;

  // a tick is processed when the result slot is free or being drained
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r   <= RST_ACTIVE_LEVEL;
      line_code_r      <= RST_LINE_CODE;
      debounce_ticks_r <= RST_DEBOUNCE_TICKS;
      click_ticks_r    <= RST_CLICK_TICKS;
      release_ticks_r  <= RST_RELEASE_TICKS;
      hold_ticks_r     <= RST_HOLD_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_LEVEL:   active_level_r   <= cfg_wdata[0];
        CFG_LINE_CODE:      line_code_r      <= cfg_wdata;
        CFG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_wdata;
        CFG_CLICK_TICKS:    click_ticks_r    <= cfg_wdata;
        CFG_RELEASE_TICKS:  release_ticks_r  <= cfg_wdata;
        CFG_HOLD_TICKS:     hold_ticks_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register, refilled whenever its tick moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pin_r       <= in_tdata[0];
      edge_line_r <= in_tdata[16:1];
      edge_seen_r <= in_tuser;
    end
  end

  // tick step: counter first, then the edge check stamped with the new tick
  assign tick_nxt      = tick_r + 1'b1;
  assign edge_hit      = edge_seen_r && (edge_line_r == line_code_r) && !settling_r;
  assign deb_stamp_nxt = edge_hit ? tick_nxt : deb_stamp_r;
  assign settle_open   = settling_r || edge_hit;

  // expiry check, zero elapsed allowed so a zero window resamples at once
  assign deb_elapsed  = tick_nxt - deb_stamp_nxt;
  assign expire       = settle_open && (deb_elapsed >= STAMP_BITS'(debounce_ticks_r));
  assign level_nxt    = expire ? pin_r : level_r;
  assign settling_nxt = settle_open && !expire;
  assign pressed      = (level_nxt == active_level_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      deb_stamp_r <= '0;
      settling_r  <= 1'b0;
      level_r     <= ~RST_ACTIVE_LEVEL;
    end else if (advance) begin
      tick_r      <= tick_nxt;
      deb_stamp_r <= deb_stamp_nxt;
      settling_r  <= settling_nxt;
      level_r     <= level_nxt;
    end
  end

  assign timing.click_ticks   = click_ticks_r;
  assign timing.release_ticks = release_ticks_r;
  assign timing.hold_ticks    = hold_ticks_r;

  bchd_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .pressed  (pressed),
    .tick_now (tick_nxt),
    .timing   (timing),
    .status   (fsm_status)
  );

  // result register, holds until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev_r    <= fsm_status.ev_code;
      out_lvl_r   <= level_nxt;
      out_state_r <= fsm_status.state_code;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_state_r, out_lvl_r, out_ev_r};

`ifndef SYNTHESIS
  // every event leaves the machine idle, or waiting for release after a hold
  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ev_r != EV_NONE |->
      out_state_r == STATE_IDLE || out_state_r == STATE_WAIT_RELEASE)
    else $error("event with unexpected machine state");

  // a hold is always followed by the release wait
  a_hold_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_ev_r == EV_HOLD |-> out_state_r == STATE_WAIT_RELEASE)
    else $error("hold without release wait");

  // the tick counter moves by one for each processed tick and never otherwise
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      tick_r == ($past(advance) ? $past(tick_r) + 1'b1 : $past(tick_r)))
    else $error("tick counter out of step");

  // the clean level only changes while a debounce window is open
  a_level_gate: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(settle_open) |-> $stable(level_r))
    else $error("clean level changed outside a debounce window");
`endif

endmodule
